FILE: sv/jts_pkg.sv
// Shared types and constants of the JSON token scanner.
// Used by the stream interfaces, the scan step, the result queue and the top level.
// No dependencies.
package jts_pkg;

    // Default width of the internal byte offsets.
    localparam int OFFSET_BITS_DEF = 24;

    // Width of the offset and length fields of a token.
    localparam int FIELD_BITS = 24;

    // Result queue depth. It must be a power of two, at least eight.
    localparam int Q_DEPTH = 8;

    // Most tokens that one byte can cause.
    localparam int MAX_TOKENS = 3;

    typedef enum logic [3:0] {
        K_LCURL   = 4'd0,
        K_RCURL   = 4'd1,
        K_LSQ     = 4'd2,
        K_RSQ     = 4'd3,
        K_COLON   = 4'd4,
        K_COMMA   = 4'd5,
        K_STRING  = 4'd6,
        K_NUMBER  = 4'd7,
        K_BOOL    = 4'd8,
        K_NULL    = 4'd9,
        K_EOF     = 4'd10,
        K_ERROR   = 4'd11
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] len;
        logic                  bval;
        logic                  run_end;
    } t_token;

    // The tokens caused by one byte, in order, and how many there are.
    typedef struct packed {
        logic [1:0]                   count;
        t_token [MAX_TOKENS-1:0]      slot;
    } t_bundle;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LCURL  = 8'h7B;
    localparam logic [7:0] CH_RCURL  = 8'h7D;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Keyword spellings, first letter in byte 0.
    localparam logic [3:0][7:0] KW_TRUE  = {"e", "u", "r", "t"};
    localparam logic [4:0][7:0] KW_FALSE = {"e", "s", "l", "a", "f"};
    localparam logic [3:0][7:0] KW_NULL  = {"l", "l", "u", "n"};

endpackage

FILE: sv/jts_stream_if.sv
// Valid/ready stream interfaces of the JSON token scanner: text bytes in, tokens out.
// Depends on jts_pkg.
interface jts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface jts_token_if;
    logic                           valid;
    logic                           ready;
    logic [3:0]                     token_kind;
    logic [jts_pkg::FIELD_BITS-1:0] start_offset;
    logic [jts_pkg::FIELD_BITS-1:0] token_length;
    logic                           bool_value;
    logic                           run_end;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output bool_value, output run_end, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input bool_value, input run_end, output ready);
endinterface

FILE: sv/jts_step.sv
// Scan step: input byte register, scanner state and the decode of one byte into tokens.
// Depends on jts_pkg and jts_byte_if.
module jts_step #(
    parameter int OFFSET_BITS = jts_pkg::OFFSET_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    jts_byte_if.sink                                  i_byte,
    input  logic [$clog2(jts_pkg::Q_DEPTH+1)-1:0]     i_level,
    output jts_pkg::t_bundle                          o_bundle
);

    localparam int FW  = jts_pkg::FIELD_BITS;
    localparam int LW  = $clog2(jts_pkg::Q_DEPTH + 1);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_STR  = 6'b000010,
        M_INT  = 6'b000100,
        M_FRAC = 6'b001000,
        M_WORD = 6'b010000,
        M_DROP = 6'b100000
    } t_mode;

    logic                   r_in_vld;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_ts, n_ts;
    logic [2:0]             r_wl, n_wl;
    logic [2:0]             r_hits, n_hits;

    logic [OFFSET_BITS-1:0] pos, nxt;
    logic                   accept;
    logic [LW:0]            need;
    jts_pkg::t_bundle       bundle;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] e,
                                                    input logic [OFFSET_BITS-1:0] s);
        return (e >= s) ? e - s : '0;
    endfunction

    function automatic jts_pkg::t_token mk_token(input jts_pkg::t_kind k,
                                                 input logic [OFFSET_BITS-1:0] s,
                                                 input logic [OFFSET_BITS-1:0] l,
                                                 input logic b);
        jts_pkg::t_token t;
        t.kind    = k;
        t.start   = FW'(s);
        t.len     = FW'(l);
        t.bval    = b;
        t.run_end = 1'b0;
        return t;
    endfunction

    // Drops each keyword that the next letter no longer matches.
    function automatic logic [2:0] word_hits(input logic [2:0] h, input logic [2:0] wl,
                                             input logic [7:0] c);
        logic [2:0] r;
        r = h;
        if (!((wl < 3'd4) && (c == jts_pkg::KW_TRUE[wl[1:0]])))  r[0] = 1'b0;
        if (!((wl < 3'd5) && (c == jts_pkg::KW_FALSE[wl])))      r[1] = 1'b0;
        if (!((wl < 3'd4) && (c == jts_pkg::KW_NULL[wl[1:0]])))  r[2] = 1'b0;
        return r;
    endfunction

    function automatic jts_pkg::t_kind word_kind(input logic [2:0] h, input logic [2:0] wl);
        if ((h[0] && wl == 3'd4) || (h[1] && wl == 3'd5)) begin
            return jts_pkg::K_BOOL;
        end else if (h[2] && wl == 3'd4) begin
            return jts_pkg::K_NULL;
        end
        return jts_pkg::K_ERROR;
    endfunction

    // Room for the byte in flight and for the new one, each with its worst case.
    assign need   = (LW+1)'(i_level) + (r_in_vld ? (LW+1)'(jts_pkg::MAX_TOKENS) : '0);
    assign i_byte.ready = need <= (LW+1)'(jts_pkg::Q_DEPTH - jts_pkg::MAX_TOKENS);
    assign accept = i_byte.valid && i_byte.ready;

    assign pos = r_off;
    assign nxt = (r_off == OFF_MAX) ? OFF_MAX : r_off + 1'b1;

    always_comb begin
        logic           consumed;
        logic [1:0]     cnt;
        jts_pkg::t_kind wk;
        logic [7:0]     c;

        c        = r_in_byte;
        n_mode   = r_mode;
        n_off    = r_off;
        n_ts     = r_ts;
        n_wl     = r_wl;
        n_hits   = r_hits;
        consumed = 1'b0;
        cnt      = 2'd0;
        wk       = jts_pkg::K_ERROR;
        bundle   = '0;

        // Bytes that continue or close the open token.
        unique case (r_mode)
            M_STR: begin
                if (c == jts_pkg::CH_QUOTE) begin
                    bundle.slot[cnt] = mk_token(jts_pkg::K_STRING, n_ts, span(pos, n_ts), 1'b0);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
                consumed = 1'b1;
            end
            M_INT: begin
                if (is_digit(c)) begin
                    consumed = 1'b1;
                end else if (c == jts_pkg::CH_DOT) begin
                    n_mode   = M_FRAC;
                    consumed = 1'b1;
                end else begin
                    bundle.slot[cnt] = mk_token(jts_pkg::K_NUMBER, n_ts, span(pos, n_ts), 1'b0);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_FRAC: begin
                if (is_digit(c)) begin
                    consumed = 1'b1;
                end else begin
                    bundle.slot[cnt] = mk_token(jts_pkg::K_NUMBER, n_ts, span(pos, n_ts), 1'b0);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_WORD: begin
                if (is_alpha(c)) begin
                    n_hits   = word_hits(n_hits, n_wl, c);
                    n_wl     = (n_wl == 3'd7) ? n_wl : n_wl + 3'd1;
                    consumed = 1'b1;
                end else begin
                    wk = word_kind(n_hits, n_wl);
                    bundle.slot[cnt] = mk_token(wk, n_ts, span(pos, n_ts),
                                                wk == jts_pkg::K_BOOL && n_hits[0] &&
                                                n_wl == 3'd4);
                    cnt = cnt + 2'd1;
                    n_mode = (wk == jts_pkg::K_ERROR) ? M_DROP : M_IDLE;
                end
            end
            M_IDLE: begin
            end
            M_DROP: begin
                consumed = 1'b1;
            end
            default: begin
                n_mode   = M_DROP;
                consumed = 1'b1;
            end
        endcase

        // A non-space byte that nothing consumed starts a token, is punctuation or is an error.
        if (!consumed && n_mode == M_IDLE && !is_space(c)) begin
            if (is_alpha(c)) begin
                n_mode = M_WORD;
                n_ts   = pos;
                n_hits = word_hits(3'b111, 3'd0, c);
                n_wl   = 3'd1;
            end else if (is_digit(c)) begin
                n_mode = M_INT;
                n_ts   = pos;
            end else begin
                case (c)
                    jts_pkg::CH_LCURL: bundle.slot[cnt] =
                        mk_token(jts_pkg::K_LCURL, pos, OFFSET_BITS'(1), 1'b0);
                    jts_pkg::CH_RCURL: bundle.slot[cnt] =
                        mk_token(jts_pkg::K_RCURL, pos, OFFSET_BITS'(1), 1'b0);
                    jts_pkg::CH_LSQ: bundle.slot[cnt] =
                        mk_token(jts_pkg::K_LSQ, pos, OFFSET_BITS'(1), 1'b0);
                    jts_pkg::CH_RSQ: bundle.slot[cnt] =
                        mk_token(jts_pkg::K_RSQ, pos, OFFSET_BITS'(1), 1'b0);
                    jts_pkg::CH_COLON: bundle.slot[cnt] =
                        mk_token(jts_pkg::K_COLON, pos, OFFSET_BITS'(1), 1'b0);
                    jts_pkg::CH_COMMA: bundle.slot[cnt] =
                        mk_token(jts_pkg::K_COMMA, pos, OFFSET_BITS'(1), 1'b0);
                    jts_pkg::CH_QUOTE: begin
                        n_mode = M_STR;
                        n_ts   = nxt;
                    end
                    default: begin
                        bundle.slot[cnt] = mk_token(jts_pkg::K_ERROR, pos, OFFSET_BITS'(1),
                                                    1'b0);
                        n_mode = M_DROP;
                    end
                endcase
                if (c != jts_pkg::CH_QUOTE) begin
                    cnt = cnt + 2'd1;
                end
            end
        end

        // The final byte closes the open token, adds the end token unless dropping, and rewinds.
        if (r_in_last) begin
            if (n_mode == M_STR) begin
                bundle.slot[cnt] = mk_token(jts_pkg::K_STRING, n_ts, span(nxt, n_ts), 1'b0);
                cnt = cnt + 2'd1;
            end else if (n_mode == M_INT || n_mode == M_FRAC) begin
                bundle.slot[cnt] = mk_token(jts_pkg::K_NUMBER, n_ts, span(nxt, n_ts), 1'b0);
                cnt = cnt + 2'd1;
            end else if (n_mode == M_WORD) begin
                wk = word_kind(n_hits, n_wl);
                bundle.slot[cnt] = mk_token(wk, n_ts, span(nxt, n_ts),
                                            wk == jts_pkg::K_BOOL && n_hits[0] &&
                                            n_wl == 3'd4);
                cnt = cnt + 2'd1;
                n_mode = (wk == jts_pkg::K_ERROR) ? M_DROP : M_IDLE;
            end
            if (n_mode != M_DROP) begin
                bundle.slot[cnt] = mk_token(jts_pkg::K_EOF, nxt, '0, 1'b0);
                cnt = cnt + 2'd1;
            end
            n_mode = M_IDLE;
            n_off  = '0;
            n_ts   = '0;
            n_wl   = 3'd0;
            n_hits = 3'b111;
        end else begin
            n_off = nxt;
        end

        if (cnt != 2'd0) begin
            bundle.slot[cnt - 2'd1].run_end = 1'b1;
        end
        bundle.count = r_in_vld ? cnt : 2'd0;
    end

    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= M_IDLE;
            r_off    <= '0;
            r_ts     <= '0;
            r_wl     <= 3'd0;
            r_hits   <= 3'b111;
        end else begin
            r_in_vld <= accept;
            if (r_in_vld) begin
                r_mode <= n_mode;
                r_off  <= n_off;
                r_ts   <= n_ts;
                r_wl   <= n_wl;
                r_hits <= n_hits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte.char_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

endmodule

FILE: sv/jts_queue.sv
// Token queue: takes up to three tokens a cycle, hands out one a cycle while the output is ready.
// Depends on jts_pkg and jts_token_if.
module jts_queue (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  jts_pkg::t_bundle                      i_bundle,
    output logic [$clog2(jts_pkg::Q_DEPTH+1)-1:0] o_level,
    jts_token_if.source                           o_token
);

    localparam int PW = $clog2(jts_pkg::Q_DEPTH);
    localparam int LW = $clog2(jts_pkg::Q_DEPTH + 1);

    jts_pkg::t_token r_mem [jts_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [LW-1:0]   r_level;
    logic            pop;
    jts_pkg::t_token head;

    assign pop     = o_token.valid && o_token.ready;
    assign o_level = r_level;
    assign head    = r_mem[r_rd];

    assign o_token.valid        = r_level != '0;
    assign o_token.token_kind   = head.kind;
    assign o_token.start_offset = head.start;
    assign o_token.token_length = head.len;
    assign o_token.bool_value   = head.bval;
    assign o_token.run_end      = head.run_end;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < jts_pkg::MAX_TOKENS; k++) begin
            if (2'(k) < i_bundle.count) begin
                r_mem[PW'(r_wr + PW'(k))] <= i_bundle.slot[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_bundle.count);
            r_rd    <= r_rd + PW'(pop);
            r_level <= r_level + LW'(i_bundle.count) - LW'(pop);
        end
    end

endmodule

FILE: sv/json_token_scanner_unit.sv
// Top level of the JSON token scanner: scan step followed by the token queue.
// Depends on jts_pkg, jts_stream_if, jts_step and jts_queue.
//
//  Channel   Direction  Item                          Payload
//  i_byte    in         one byte of JSON text         char_byte, last_byte
//  o_token   out        one token                     token_kind, start_offset,
//                                                     token_length, bool_value, run_end
//
// A byte accepted at one edge is held in an input register and decoded in the next
// cycle; its tokens (zero to three) are written to an eight-entry queue at that edge
// and the first can leave in the cycle after. The scanner takes one byte per cycle
// while the queue has room; the queue hands out one token per cycle while the output
// is ready, so bytes that cause two or three tokens slow the input to the token rate.
// Input ready depends only on registered state, the queue fill and whether the input
// register is full, so a stalled output never reaches the input in the same cycle.
// Reset is synchronous and clears the scanner to idle at offset zero and empties
// the queue; queue entries and the input byte register are not reset.
//
// The scanner skips whitespace and reports punctuation, strings without escapes,
// numbers with an optional fraction and the words true, false and null. The final
// byte of a text closes any open token and adds an end token. An unknown word or
// symbol gives an error token, after which bytes are dropped through the final byte.
// Offsets are OFFSET_BITS wide and stick at their largest value; the token fields
// carry their low bits.
module json_token_scanner_unit #(
    parameter int OFFSET_BITS = jts_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jts_byte_if.sink    i_byte,
    jts_token_if.source o_token
);

    logic [$clog2(jts_pkg::Q_DEPTH+1)-1:0] level;
    jts_pkg::t_bundle                      bundle;

    jts_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_level  (level),
        .o_bundle (bundle)
    );

    jts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (bundle),
        .o_level  (level),
        .o_token  (o_token)
    );

endmodule

FILE: test/json_token_scanner_unit_test.sv
// Self-checking bench for the JSON token scanner: byte stream in, token stream out.
// Depends on jts_pkg, jts_stream_if and json_token_scanner_unit.
`timescale 1ns / 100ps

module json_token_scanner_unit_test;

    // A narrow offset checks that the offset width is carried down to the fields.
    localparam int OFF_BITS    = 10;
    localparam int IDLE_PCT    = 38;
    localparam int RANDOM_BYTES = 240;
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [OFF_BITS-1:0] t_off;
    localparam t_off OFF_SAT = '1;

    typedef enum logic [2:0] {
        LX_IDLE, LX_STRING, LX_INT, LX_FRAC, LX_WORD, LX_DROP
    } t_lex_mode;

    // One row of the directed script. Pinned rows carry their single token typed in.
    typedef struct {
        logic [7:0]      ch;
        logic            fin;
        logic            pin;
        jts_pkg::t_token want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jts_byte_if  byte_ch ();
    jts_token_if token_ch ();

    json_token_scanner_unit #(
        .OFFSET_BITS (OFF_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_token (token_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow lexer state.
    t_lex_mode lex_mode;
    t_off      next_off;
    t_off      open_start;
    logic [2:0] word_len;
    logic [2:0] kw_live;   // bit 0 true, bit 1 false, bit 2 null

    jts_pkg::t_token step_tok [jts_pkg::MAX_TOKENS];
    int              step_n;

    jts_pkg::t_token expected_tokens [$];
    t_row            script [$];
    logic [7:0]      text_q [$];

    logic            pin_now;
    jts_pkg::t_token want_now;
    logic            steady;
    int              error_count = 0;
    int              bytes_sent = 0;
    int              cycle_count = 0;

    function automatic void row(logic [7:0] ch, logic fin);
        script.push_back('{ch: ch, fin: fin, pin: 1'b0, want: '0});
    endfunction

    function automatic void pin_row(logic [7:0] ch, logic fin, jts_pkg::t_kind k, int st,
                                    int ln);
        jts_pkg::t_token w;
        w = '{kind: k, start: jts_pkg::FIELD_BITS'(st), len: jts_pkg::FIELD_BITS'(ln),
              bval: 1'b0, run_end: 1'b1};
        script.push_back('{ch: ch, fin: fin, pin: 1'b1, want: w});
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] w;
        w = 8'($urandom_range(8, 13));
        return (w == 8'd8) ? 8'h20 : w;
    endfunction

    function automatic logic [7:0] punct_byte();
        case ($urandom_range(0, 5))
            0: return jts_pkg::CH_LCURL;
            1: return jts_pkg::CH_RCURL;
            2: return jts_pkg::CH_LSQ;
            3: return jts_pkg::CH_RSQ;
            4: return jts_pkg::CH_COLON;
            default: return jts_pkg::CH_COMMA;
        endcase
    endfunction

    function automatic void lex_reset();
        lex_mode   = LX_IDLE;
        next_off   = '0;
        open_start = '0;
        word_len   = '0;
        kw_live    = 3'b111;
    endfunction

    function automatic void add_token(jts_pkg::t_kind k, t_off st, t_off ln, logic bv);
        if (step_n < jts_pkg::MAX_TOKENS) begin
            step_tok[step_n] = '{kind: k, start: jts_pkg::FIELD_BITS'(st),
                                 len: jts_pkg::FIELD_BITS'(ln), bval: bv, run_end: 1'b0};
            step_n++;
        end
    endfunction

    // Length of the open token up to offset e; never negative.
    function automatic t_off open_len(t_off e);
        return (e >= open_start) ? t_off'(e - open_start) : '0;
    endfunction

    // Letters past a keyword's spelling, or that differ from it, knock that keyword out.
    function automatic void take_letter(logic [7:0] c);
        if (word_len >= 3'd4 || c != jts_pkg::KW_TRUE[word_len[1:0]])
            kw_live[0] = 1'b0;
        if (word_len >= 3'd5 || c != jts_pkg::KW_FALSE[word_len])
            kw_live[1] = 1'b0;
        if (word_len >= 3'd4 || c != jts_pkg::KW_NULL[word_len[1:0]])
            kw_live[2] = 1'b0;
        if (word_len < 3'd7)
            word_len++;
    endfunction

    function automatic void close_word(t_off e);
        t_off n;
        n = open_len(e);
        if (kw_live[0] && word_len == 3'd4) begin
            add_token(jts_pkg::K_BOOL, open_start, n, 1'b1);
            lex_mode = LX_IDLE;
        end else if (kw_live[1] && word_len == 3'd5) begin
            add_token(jts_pkg::K_BOOL, open_start, n, 1'b0);
            lex_mode = LX_IDLE;
        end else if (kw_live[2] && word_len == 3'd4) begin
            add_token(jts_pkg::K_NULL, open_start, n, 1'b0);
            lex_mode = LX_IDLE;
        end else begin
            add_token(jts_pkg::K_ERROR, open_start, n, 1'b0);
            lex_mode = LX_DROP;
        end
    endfunction

    // Advance the shadow lexer by one byte and leave its tokens in step_tok.
    function automatic void lex_byte(logic [7:0] c, logic fin);
        t_off pos;
        t_off nxt;
        logic used;
        pos  = next_off;
        nxt  = (pos == OFF_SAT) ? pos : t_off'(pos + 1'b1);
        used = 1'b0;
        step_n = 0;

        case (lex_mode)
            LX_STRING: begin
                if (c == jts_pkg::CH_QUOTE) begin
                    add_token(jts_pkg::K_STRING, open_start, open_len(pos), 1'b0);
                    lex_mode = LX_IDLE;
                end
                used = 1'b1;
            end
            LX_INT, LX_FRAC: begin
                if (is_digit(c)) begin
                    used = 1'b1;
                end else if (c == jts_pkg::CH_DOT && lex_mode == LX_INT) begin
                    lex_mode = LX_FRAC;
                    used = 1'b1;
                end else begin
                    add_token(jts_pkg::K_NUMBER, open_start, open_len(pos), 1'b0);
                    lex_mode = LX_IDLE;
                end
            end
            LX_WORD: begin
                if (is_letter(c)) begin
                    take_letter(c);
                    used = 1'b1;
                end else begin
                    close_word(pos);
                end
            end
            LX_DROP: used = 1'b1;
            default: used = 1'b0;
        endcase

        // A byte not taken by an open token is scanned from idle; a bad word's
        // terminator is not, since the word has already moved on to dropping.
        if (!used && lex_mode == LX_IDLE) begin
            if (is_letter(c)) begin
                lex_mode   = LX_WORD;
                open_start = pos;
                word_len   = '0;
                kw_live    = 3'b111;
                take_letter(c);
            end else if (is_digit(c)) begin
                lex_mode   = LX_INT;
                open_start = pos;
            end else if (!(c == 8'h20 || (c >= 8'd9 && c <= 8'd13))) begin
                case (c)
                    jts_pkg::CH_LCURL: add_token(jts_pkg::K_LCURL, pos, t_off'(1), 1'b0);
                    jts_pkg::CH_RCURL: add_token(jts_pkg::K_RCURL, pos, t_off'(1), 1'b0);
                    jts_pkg::CH_LSQ:   add_token(jts_pkg::K_LSQ, pos, t_off'(1), 1'b0);
                    jts_pkg::CH_RSQ:   add_token(jts_pkg::K_RSQ, pos, t_off'(1), 1'b0);
                    jts_pkg::CH_COLON: add_token(jts_pkg::K_COLON, pos, t_off'(1), 1'b0);
                    jts_pkg::CH_COMMA: add_token(jts_pkg::K_COMMA, pos, t_off'(1), 1'b0);
                    jts_pkg::CH_QUOTE: begin
                        lex_mode   = LX_STRING;
                        open_start = nxt;
                    end
                    default: begin
                        add_token(jts_pkg::K_ERROR, pos, t_off'(1), 1'b0);
                        lex_mode = LX_DROP;
                    end
                endcase
            end
        end

        // The final byte closes whatever is open; a text that hit an error has no end token.
        if (fin) begin
            case (lex_mode)
                LX_STRING:       add_token(jts_pkg::K_STRING, open_start, open_len(nxt),
                                           1'b0);
                LX_INT, LX_FRAC: add_token(jts_pkg::K_NUMBER, open_start, open_len(nxt),
                                           1'b0);
                LX_WORD:         close_word(nxt);
                default:         step_n = step_n;
            endcase
            if (lex_mode != LX_DROP)
                add_token(jts_pkg::K_EOF, nxt, '0, 1'b0);
            lex_reset();
        end else begin
            next_off = nxt;
        end

        if (step_n > 0)
            step_tok[step_n-1].run_end = 1'b1;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endfunction

    // Byte side: every accepted item steps the shadow lexer.
    always @(posedge i_clk) begin : byte_monitor
        int k;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            lex_byte(byte_ch.char_byte, byte_ch.last_byte);
            if (pin_now) begin
                expected_tokens.push_back(want_now);
            end else begin
                for (k = 0; k < step_n; k++)
                    expected_tokens.push_back(step_tok[k]);
            end
        end
    end

    // Token side: each accepted item is matched against the oldest expectation.
    always @(posedge i_clk) begin : token_monitor
        jts_pkg::t_token want;
        if (i_rst_n && token_ch.valid && token_ch.ready) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t ns: token with none expected, kind %0d start %0d length %0d",
                         $time, token_ch.token_kind, token_ch.start_offset,
                         token_ch.token_length);
                error_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("kind", 32'(want.kind), 32'(token_ch.token_kind));
                check_field("start", 32'(want.start), 32'(token_ch.start_offset));
                check_field("length", 32'(want.len), 32'(token_ch.token_length));
                check_field("bool", 32'(want.bval), 32'(token_ch.bool_value));
                check_field("run_end", 32'(want.run_end), 32'(token_ch.run_end));
            end
        end
    end

    always @(negedge i_clk)
        token_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("json_token_scanner_unit regression: fail");
            $finish;
        end
    end

    // Called and returns at a falling edge. Valid stays high between back-to-back
    // items and is lowered here only by a gap, so it never toggles within one step.
    task automatic send_byte(logic [7:0] ch, logic fin, logic pin, jts_pkg::t_token want);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.char_byte <= ch;
        byte_ch.last_byte <= fin;
        pin_now  <= pin;
        want_now <= want;
        do
            @(posedge i_clk);
        while (byte_ch.ready !== 1'b1);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[k])
            send_byte(text_q[k], k == text_q.size() - 1, 1'b0, '0);
    endtask

    // Sender holds off until every token owed so far has come out.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_tokens.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int k;
        int n;
        int text_no;
        logic [7:0] b;

        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.char_byte  = '0;
        byte_ch.last_byte  = 1'b0;
        token_ch.ready     = 1'b0;
        pin_now            = 1'b0;
        want_now           = '0;
        steady             = 1'b0;
        lex_reset();

        // Punctuation, an empty string, a number whose dot has no digits, null,
        // and a quote as the final byte.
        pin_row(jts_pkg::CH_LCURL, 1'b0, jts_pkg::K_LCURL, 0, 1);
        row(jts_pkg::CH_QUOTE, 1'b0);
        row(jts_pkg::CH_QUOTE, 1'b0);
        pin_row(jts_pkg::CH_COLON, 1'b0, jts_pkg::K_COLON, 3, 1);
        row("9", 1'b0);
        row(jts_pkg::CH_DOT, 1'b0);
        row(jts_pkg::CH_COMMA, 1'b0);
        pin_row(jts_pkg::CH_LSQ, 1'b0, jts_pkg::K_LSQ, 7, 1);
        row("n", 1'b0);
        row("u", 1'b0);
        row("l", 1'b0);
        row("l", 1'b0);
        row(jts_pkg::CH_RSQ, 1'b0);
        row(jts_pkg::CH_RCURL, 1'b0);
        row(jts_pkg::CH_QUOTE, 1'b1);
        // A keyword closed by the final byte.
        row("f", 1'b0);
        row("a", 1'b0);
        row("l", 1'b0);
        row("s", 1'b0);
        row("e", 1'b1);
        // A high byte as a bad symbol, then the rest of the text is dropped.
        pin_row(8'hFF, 1'b0, jts_pkg::K_ERROR, 0, 1);
        row(8'h00, 1'b1);
        // An unterminated string that takes in the final byte.
        row(jts_pkg::CH_QUOTE, 1'b0);
        row("z", 1'b1);
        // A bad word ended by the final byte: error with no end token.
        row("x", 1'b0);
        pin_row(8'h00, 1'b1, jts_pkg::K_ERROR, 0, 1);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[r])
            send_byte(script[r].ch, script[r].fin, script[r].pin, script[r].want);
        wait_drained();

        // Random texts, mostly well-formed tokens with random content. A stretch
        // of texts runs with neither side idling.
        bytes_sent = 0;
        text_no = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            steady = (text_no >= 3 && text_no < 7);
            if (text_no == 9)
                wait_drained();
            text_q.delete();
            repeat ($urandom_range(2, 10)) begin
                case ($urandom_range(0, 99)) inside
                    [0:29]: text_q.push_back(punct_byte());
                    [30:44]: begin
                        text_q.push_back(jts_pkg::CH_QUOTE);
                        repeat ($urandom_range(0, 6)) begin
                            b = 8'($urandom_range(0, 255));
                            text_q.push_back(b == jts_pkg::CH_QUOTE ? jts_pkg::CH_DOT : b);
                        end
                        // Now and then the closing quote is left out and the string runs on.
                        if ($urandom_range(0, 99) < 85)
                            text_q.push_back(jts_pkg::CH_QUOTE);
                    end
                    [45:59]: begin
                        repeat ($urandom_range(1, 4))
                            text_q.push_back(8'("0" + $urandom_range(0, 9)));
                        if ($urandom_range(0, 1)) begin
                            text_q.push_back(jts_pkg::CH_DOT);
                            repeat ($urandom_range(0, 3))
                                text_q.push_back(8'("0" + $urandom_range(0, 9)));
                        end
                        if ($urandom_range(0, 4) != 0)
                            text_q.push_back($urandom_range(0, 1) ? blank_byte()
                                                                  : punct_byte());
                    end
                    [60:74]: begin
                        case ($urandom_range(0, 2))
                            0: for (k = 0; k < 4; k++) text_q.push_back(jts_pkg::KW_TRUE[k]);
                            1: for (k = 0; k < 5; k++) text_q.push_back(jts_pkg::KW_FALSE[k]);
                            default: for (k = 0; k < 4; k++)
                                text_q.push_back(jts_pkg::KW_NULL[k]);
                        endcase
                        // A clipped or stretched keyword is a bad word.
                        n = $urandom_range(0, 9);
                        if (n == 0)
                            void'(text_q.pop_back());
                        else if (n == 1)
                            text_q.push_back("e");
                        if ($urandom_range(0, 4) != 0)
                            text_q.push_back($urandom_range(0, 1) ? blank_byte()
                                                                  : punct_byte());
                    end
                    [75:87]: text_q.push_back(blank_byte());
                    [88:93]: begin
                        repeat ($urandom_range(1, 8))
                            text_q.push_back($urandom_range(0, 1)
                                ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25)));
                        text_q.push_back(blank_byte());
                    end
                    default: text_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            send_text();
            text_no++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (error_count == 0)
            $display("json_token_scanner_unit regression: pass");
        else
            $display("json_token_scanner_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/jts_pkg.sv
sv/jts_stream_if.sv
sv/jts_step.sv
sv/jts_queue.sv
sv/json_token_scanner_unit.sv
test/json_token_scanner_unit_test.sv
